>>> sv/widft_pkg.sv
// ----------------------------------------------------------------------------
// Windowed inverse DFT package
// Shared constants, codes and the build-time window and twiddle tables.
// ----------------------------------------------------------------------------
package widft_pkg;

  localparam int MAX_POINTS      = 64;
  localparam int DEF_POINTS      = 64;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int FREQ_W          = 40;
  localparam int TOL_W           = 16;
  localparam int WIN_W           = 17;
  localparam int TW_W            = 22;
  localparam int TIDX_W          = 6;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIF_TOL    = 1'd1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

  typedef enum logic [1:0] {
    WIN_RECT,
    WIN_HANN,
    WIN_HAMMING,
    WIN_BLACKMAN
  } window_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ORDER,
    ST_UNIFORM
  } status_e;

  typedef logic [WIN_W-1:0]       win_tab_t [MAX_POINTS];
  typedef logic signed [TW_W-1:0] tw_tab_t  [MAX_POINTS];

  // Quarter-wave sine, Q0.30 in and out.
  function automatic logic [63:0] quarter_sin(input logic [63:0] u);
    logic [63:0] coef [6];
    logic [63:0] u2;
    logic [63:0] p;
    coef[0] = 64'd1686629713;
    coef[1] = 64'd693598668;
    coef[2] = 64'd85569306;
    coef[3] = 64'd5026995;
    coef[4] = 64'd172272;
    coef[5] = 64'd3864;
    u2 = (u * u) >> 30;
    p  = coef[5];
    for (int k = 4; k >= 0; k--) begin
      p = coef[k] - ((u2 * p) >> 30);
    end
    return (u * p) >> 30;
  endfunction

  function automatic logic signed [63:0] sin_turn(input logic [31:0] t);
    logic [1:0]  q;
    logic [63:0] f;
    logic [63:0] u;
    logic [63:0] m;
    q = t[31:30];
    f = {34'd0, t[29:0]};
    u = q[0] ? ((64'd1 << 30) - f) : f;
    m = quarter_sin(u);
    return q[1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] cos_turn(input logic [31:0] t);
    return sin_turn(t + 32'h4000_0000);
  endfunction

  // Fraction of a turn num/den in Q0.32, rounded half up, by long division.
  function automatic logic [31:0] turn_of(input int unsigned num, input int unsigned den);
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] dvd;
    logic [63:0] quo;
    logic [63:0] rem;
    d = 64'(den);
    r = 64'(num);
    for (int i = 0; i < 256; i++) begin
      if (r >= d) r = r - d;
    end
    dvd = (r << 32) + (d >> 1);
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], dvd[b]};
      quo = quo << 1;
      if (rem >= d) begin
        rem    = rem - d;
        quo[0] = 1'b1;
      end
    end
    return quo[31:0];
  endfunction

  function automatic logic [WIN_W-1:0] window_q16(input logic [1:0] kind,
                                                  input int unsigned i,
                                                  input int unsigned points);
    logic signed [63:0] a0;
    logic signed [63:0] a1;
    logic signed [63:0] a2;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic signed [63:0] acc;
    a0 = 64'sd450971566;
    a1 = 64'sd536870912;
    a2 = 64'sd85899346;
    case (kind)
      WIN_RECT:    return 17'd65536;
      WIN_HANN:    begin a0 = 64'sd536870912; a1 = 64'sd536870912; a2 = 64'sd0; end
      WIN_HAMMING: begin a0 = 64'sd579820585; a1 = 64'sd493921239; a2 = 64'sd0; end
      default:     ;
    endcase
    c1  = cos_turn(turn_of(i, points - 1));
    c2  = cos_turn(turn_of(2 * i, points - 1));
    acc = a0 * (64'sd1 <<< 30) - a1 * c1 + a2 * c2;
    acc = (acc + (64'sd1 <<< 43)) >>> 44;
    if (acc < 0) acc = 64'sd0;
    if (acc > 64'sd65536) acc = 64'sd65536;
    return acc[WIN_W-1:0];
  endfunction

  function automatic win_tab_t build_win(input logic [1:0] kind, input int unsigned points);
    win_tab_t tab;
    for (int i = 0; i < MAX_POINTS; i++) begin
      tab[i] = (i < points) ? window_q16(kind, i, points) : '0;
    end
    return tab;
  endfunction

  function automatic tw_tab_t build_tw(input logic use_sin, input int unsigned points);
    tw_tab_t            tab;
    logic signed [63:0] v;
    for (int i = 0; i < MAX_POINTS; i++) begin
      v = '0;
      if (i < points) begin
        v = use_sin ? sin_turn(turn_of(i, points)) : cos_turn(turn_of(i, points));
        v = (v + 64'sd512) >>> 10;
      end
      tab[i] = v[TW_W-1:0];
    end
    return tab;
  endfunction

endpackage

>>> sv/widft_cell.sv
// ----------------------------------------------------------------------------
// Sweep cell
// One point of the sweep: frequency and complex sample, passed to the
// neighbor cell on every shift of the ring.
// ----------------------------------------------------------------------------
module widft_cell
  import widft_pkg::*;
#(
  parameter int SW = DEF_SAMPLE_BITS + 2
) (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic [FREQ_W-1:0]        freq_i,
  input  logic signed [SW-1:0]     re_i,
  input  logic signed [SW-1:0]     im_i,
  output logic [FREQ_W-1:0]        freq_o,
  output logic signed [SW-1:0]     re_o,
  output logic signed [SW-1:0]     im_o
);

  logic [FREQ_W-1:0]    freq_q;
  logic signed [SW-1:0] re_q;
  logic signed [SW-1:0] im_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      freq_q <= freq_i;
      re_q   <= re_i;
      im_q   <= im_i;
    end
  end

  assign freq_o = freq_q;
  assign re_o   = re_q;
  assign im_o   = im_q;

endmodule

>>> sv/widft_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Division of an unsigned value by a fixed divisor through multiplication
// with its rounded-up reciprocal; the quotient is ready in the cycle after start.
// ----------------------------------------------------------------------------
module widft_div
  import widft_pkg::*;
#(
  parameter int WIDTH   = 24,
  parameter int DIVISOR = DEF_POINTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  // With RS = WIDTH + ceil(log2(DIVISOR)) the truncated product is exact for
  // every dividend below 2^WIDTH.
  localparam int RS    = WIDTH + $clog2(DIVISOR);
  localparam int PRD_W = WIDTH + RS;
  localparam logic [RS-1:0] RECIP =
    RS'(((64'd1 << RS) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PRD_W-1:0] prod_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PRD_W'(dividend_i) * PRD_W'(RECIP);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = prod_q[PRD_W-1:RS];

endmodule

>>> sv/windowed_inverse_dft.sv
// ----------------------------------------------------------------------------
// Windowed inverse DFT
// Loads a sweep of POINTS points, checks it, windows it and returns the
// scaled inverse DFT one time bin at a time.
// ----------------------------------------------------------------------------
// The input channel takes one sweep point per transfer: frequency and a
// complex sample. While a sweep loads, one point is taken every cycle. After
// the last point the block goes busy: one pass checks the frequency steps,
// one pass applies the window, and then each time bin takes a pass on the
// single complex multiply-accumulate unit, a drain of the multiply pipeline,
// the reciprocal scaling by 1/POINTS and a wait in the output register.
// A failed check gives one error transfer with last set instead of bins.
// Each result waits in the output register until it is taken; a stalled
// receiver simply holds the block in place. Input is refused until the last
// result of the sweep is transferred. Configuration is written through a
// plain write port; the user is to write it only while the block is idle,
// which the block itself does not enforce. Reset returns the block to an
// empty load with the register reset values.
// ----------------------------------------------------------------------------
module windowed_inverse_dft
  import widft_pkg::*;
#(
  parameter int POINTS      = DEF_POINTS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [FREQ_W-1:0]             freq_hz_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [TIDX_W-1:0]             time_index_o,
  output logic signed [SAMPLE_BITS-1:0] resp_re_o,
  output logic signed [SAMPLE_BITS-1:0] resp_im_o,
  output logic                          last_o
);

  localparam int PW       = $clog2(POINTS);
  localparam int SW       = SAMPLE_BITS + 2;
  localparam int PR_W     = SW + WIN_W + 1;
  localparam int MP_W     = SW + TW_W;
  localparam int ACC_W    = SAMPLE_BITS + 25 + $clog2(POINTS);
  localparam int QW       = ACC_W - 21;
  localparam int SCALED_W = FREQ_W + $clog2(POINTS);
  localparam int CMP_W    = SCALED_W + TOL_W;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SPAN   = 4'd1;
  localparam logic [3:0] S_TOL    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_WEIGHT = 4'd5;
  localparam logic [3:0] S_MAC    = 4'd6;
  localparam logic [3:0] S_DRAIN  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam win_tab_t WIN_RECT_TAB  = build_win(WIN_RECT, POINTS);
  localparam win_tab_t WIN_HANN_TAB  = build_win(WIN_HANN, POINTS);
  localparam win_tab_t WIN_HAMM_TAB  = build_win(WIN_HAMMING, POINTS);
  localparam win_tab_t WIN_BLACK_TAB = build_win(WIN_BLACKMAN, POINTS);
  localparam tw_tab_t  COS_TAB       = build_tw(1'b0, POINTS);
  localparam tw_tab_t  SIN_TAB       = build_tw(1'b1, POINTS);

  localparam logic signed [PR_W-1:0]  W_HALF    = PR_W'(8192);
  localparam logic signed [ACC_W:0]   RND_BIAS  = (ACC_W + 1)'(POINTS) <<< 21;
  localparam logic signed [QW:0]      SAT_HI    =
    (QW + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [QW:0]      SAT_LO    = -SAT_HI - 1;
  localparam logic [PW-1:0]           LAST_IDX  = PW'(POINTS - 1);

  logic [3:0]        state_q;
  logic [PW-1:0]     ld_q;
  logic [PW-1:0]     cnt_q;
  logic [PW-1:0]     m_q;
  logic [PW-1:0]     tw_q;
  logic [1:0]        err_q;
  logic              s1v_q;
  logic              av_q;
  logic              bv_q;
  logic              out_valid_q;
  logic [1:0]        win_type_q;
  logic [TOL_W-1:0]  tol_q;

  logic [FREQ_W-1:0]         span_q;
  logic [TOL_W+FREQ_W-1:0]   tolspan_q;
  logic [FREQ_W-1:0]         step_q;
  logic                      notinc_q;
  logic signed [SW-1:0]      a_re_q;
  logic signed [SW-1:0]      a_im_q;
  logic signed [TW_W-1:0]    a_c_q;
  logic signed [TW_W-1:0]    a_s_q;
  logic signed [MP_W-1:0]    b_rc_q;
  logic signed [MP_W-1:0]    b_is_q;
  logic signed [MP_W-1:0]    b_rs_q;
  logic signed [MP_W-1:0]    b_ic_q;
  logic signed [ACC_W-1:0]   acc_re_q;
  logic signed [ACC_W-1:0]   acc_im_q;
  logic                      neg_re_q;
  logic                      neg_im_q;
  logic [1:0]                status_q;
  logic [TIDX_W-1:0]         tidx_q;
  logic signed [SAMPLE_BITS-1:0] res_re_q;
  logic signed [SAMPLE_BITS-1:0] res_im_q;
  logic                      last_q;

  logic [FREQ_W-1:0]    freq_c   [POINTS];
  logic signed [SW-1:0] re_c     [POINTS];
  logic signed [SW-1:0] im_c     [POINTS];
  logic [FREQ_W-1:0]    freq_nx  [POINTS];
  logic signed [SW-1:0] re_nx    [POINTS];
  logic signed [SW-1:0] im_nx    [POINTS];
  logic [FREQ_W-1:0]    tail_freq;
  logic signed [SW-1:0] tail_re;
  logic signed [SW-1:0] tail_im;
  logic                 ring_shift;

  logic                    in_xfer;
  logic                    out_xfer;
  logic [WIN_W-1:0]        win_w;
  logic signed [PR_W-1:0]  prod_re;
  logic signed [PR_W-1:0]  prod_im;
  logic signed [PR_W-1:0]  rnd_re;
  logic signed [PR_W-1:0]  rnd_im;
  logic [PW:0]             tw_sum;
  logic [PW-1:0]           tw_next;
  logic [SCALED_W-1:0]     scaled;
  logic [SCALED_W-1:0]     span_ext;
  logic [SCALED_W-1:0]     diff;
  logic                    unif_fail;
  logic signed [ACC_W:0]   y_re;
  logic signed [ACC_W:0]   y_im;
  logic signed [QW-1:0]    q_re;
  logic signed [QW-1:0]    q_im;
  logic [QW-1:0]           mag_re;
  logic [QW-1:0]           mag_im;
  logic                    div_start;
  logic                    div_done;
  logic                    div_done_im;
  logic [QW-1:0]           quo_re;
  logic [QW-1:0]           quo_im;
  logic signed [QW:0]      r_re;
  logic signed [QW:0]      r_im;
  logic signed [SAMPLE_BITS-1:0] sat_re;
  logic signed [SAMPLE_BITS-1:0] sat_im;
  logic                    acc_clr;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  // Ring of sweep cells; cell 0 is the head, new data enters at the tail.
  assign ring_shift = in_xfer || (state_q == S_CHECK) || (state_q == S_WEIGHT) ||
                      (state_q == S_MAC);

  always_comb begin
    case (state_q)
      S_LOAD: begin
        tail_freq = freq_hz_i;
        tail_re   = SW'(sample_re_i);
        tail_im   = SW'(sample_im_i);
      end
      S_WEIGHT: begin
        tail_freq = freq_c[0];
        tail_re   = rnd_re[SW-1:0];
        tail_im   = rnd_im[SW-1:0];
      end
      default: begin
        tail_freq = freq_c[0];
        tail_re   = re_c[0];
        tail_im   = im_c[0];
      end
    endcase
  end

  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    if (i == POINTS - 1) begin : g_tail
      assign freq_nx[i] = tail_freq;
      assign re_nx[i]   = tail_re;
      assign im_nx[i]   = tail_im;
    end else begin : g_body
      assign freq_nx[i] = freq_c[i+1];
      assign re_nx[i]   = re_c[i+1];
      assign im_nx[i]   = im_c[i+1];
    end
    widft_cell #(
      .SW(SW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (ring_shift),
      .freq_i  (freq_nx[i]),
      .re_i    (re_nx[i]),
      .im_i    (im_nx[i]),
      .freq_o  (freq_c[i]),
      .re_o    (re_c[i]),
      .im_o    (im_c[i])
    );
  end

  always_comb begin
    case (win_type_q)
      WIN_RECT:    win_w = WIN_RECT_TAB[TIDX_W'(cnt_q)];
      WIN_HANN:    win_w = WIN_HANN_TAB[TIDX_W'(cnt_q)];
      WIN_HAMMING: win_w = WIN_HAMM_TAB[TIDX_W'(cnt_q)];
      default:     win_w = WIN_BLACK_TAB[TIDX_W'(cnt_q)];
    endcase
  end

  assign prod_re = re_c[0] * $signed({1'b0, win_w});
  assign prod_im = im_c[0] * $signed({1'b0, win_w});
  assign rnd_re  = (prod_re + W_HALF) >>> 14;
  assign rnd_im  = (prod_im + W_HALF) >>> 14;

  assign tw_sum  = {1'b0, tw_q} + {1'b0, m_q};
  assign tw_next = (tw_sum >= (PW + 1)'(POINTS)) ? PW'(tw_sum - (PW + 1)'(POINTS))
                                                 : tw_sum[PW-1:0];

  assign scaled    = SCALED_W'(step_q) * SCALED_W'(POINTS - 1);
  assign span_ext  = SCALED_W'(span_q);
  assign diff      = (scaled > span_ext) ? (scaled - span_ext) : (span_ext - scaled);
  assign unif_fail = ({diff, {TOL_W{1'b0}}} > CMP_W'(tolspan_q));

  assign y_re   = {acc_re_q[ACC_W-1], acc_re_q} + RND_BIAS;
  assign y_im   = {acc_im_q[ACC_W-1], acc_im_q} + RND_BIAS;
  assign q_re   = y_re[ACC_W:22];
  assign q_im   = y_im[ACC_W:22];
  assign mag_re = q_re[QW-1] ? QW'(-q_re + QW'(POINTS - 1)) : q_re;
  assign mag_im = q_im[QW-1] ? QW'(-q_im + QW'(POINTS - 1)) : q_im;

  assign div_start = (state_q == S_DRAIN) && !av_q && !bv_q;

  widft_div #(
    .WIDTH   (QW),
    .DIVISOR (POINTS)
  ) u_div_re (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_re),
    .done_o     (div_done),
    .quotient_o (quo_re)
  );

  widft_div #(
    .WIDTH   (QW),
    .DIVISOR (POINTS)
  ) u_div_im (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_im),
    .done_o     (div_done_im),
    .quotient_o (quo_im)
  );

  assign r_re = neg_re_q ? -$signed({1'b0, quo_re}) : $signed({1'b0, quo_re});
  assign r_im = neg_im_q ? -$signed({1'b0, quo_im}) : $signed({1'b0, quo_im});

  always_comb begin
    if (r_re > SAT_HI) sat_re = SAT_HI[SAMPLE_BITS-1:0];
    else if (r_re < SAT_LO) sat_re = SAT_LO[SAMPLE_BITS-1:0];
    else sat_re = r_re[SAMPLE_BITS-1:0];
    if (r_im > SAT_HI) sat_im = SAT_HI[SAMPLE_BITS-1:0];
    else if (r_im < SAT_LO) sat_im = SAT_LO[SAMPLE_BITS-1:0];
    else sat_im = r_im[SAMPLE_BITS-1:0];
  end

  assign acc_clr = (state_q == S_WEIGHT) || ((state_q == S_OUT) && out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ld_q        <= '0;
      cnt_q       <= '0;
      m_q         <= '0;
      tw_q        <= '0;
      err_q       <= ST_OK;
      s1v_q       <= 1'b0;
      av_q        <= 1'b0;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      win_type_q  <= WIN_RECT;
      tol_q       <= TOL_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WINDOW_TYPE: win_type_q <= cfg_data_i[1:0];
          CFG_UNIF_TOL:    tol_q      <= cfg_data_i[TOL_W-1:0];
          default:         ;
        endcase
      end
      s1v_q <= (state_q == S_CHECK) && (cnt_q != LAST_IDX);
      av_q  <= (state_q == S_MAC);
      bv_q  <= av_q;
      if (s1v_q && (err_q == ST_OK)) begin
        if (notinc_q) err_q <= ST_ORDER;
        else if (unif_fail) err_q <= ST_UNIFORM;
      end
      case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            if (ld_q == LAST_IDX) begin
              ld_q    <= '0;
              state_q <= S_SPAN;
            end else begin
              ld_q <= ld_q + 1'b1;
            end
          end
        end
        S_SPAN: begin
          err_q   <= (freq_c[POINTS-1] <= freq_c[0]) ? ST_ORDER : ST_OK;
          state_q <= S_TOL;
        end
        S_TOL: begin
          cnt_q   <= '0;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= S_DECIDE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DECIDE: begin
          cnt_q <= '0;
          if (err_q != ST_OK) begin
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_WEIGHT;
          end
        end
        S_WEIGHT: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            m_q     <= '0;
            tw_q    <= '0;
            state_q <= S_MAC;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MAC: begin
          tw_q <= tw_next;
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (div_start) state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_LOAD;
            end else begin
              m_q     <= m_q + 1'b1;
              tw_q    <= '0;
              cnt_q   <= '0;
              state_q <= S_MAC;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SPAN) span_q <= freq_c[POINTS-1] - freq_c[0];
    if (state_q == S_TOL) tolspan_q <= (TOL_W + FREQ_W)'(tol_q) * (TOL_W + FREQ_W)'(span_q);
    step_q   <= freq_c[1] - freq_c[0];
    notinc_q <= (freq_c[1] <= freq_c[0]);

    a_re_q <= re_c[0];
    a_im_q <= im_c[0];
    a_c_q  <= COS_TAB[TIDX_W'(tw_q)];
    a_s_q  <= SIN_TAB[TIDX_W'(tw_q)];
    b_rc_q <= MP_W'(a_re_q) * MP_W'(a_c_q);
    b_is_q <= MP_W'(a_im_q) * MP_W'(a_s_q);
    b_rs_q <= MP_W'(a_re_q) * MP_W'(a_s_q);
    b_ic_q <= MP_W'(a_im_q) * MP_W'(a_c_q);
    if (acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (bv_q) begin
      acc_re_q <= acc_re_q + ACC_W'(b_rc_q) - ACC_W'(b_is_q);
      acc_im_q <= acc_im_q + ACC_W'(b_rs_q) + ACC_W'(b_ic_q);
    end

    if (div_start) begin
      neg_re_q <= q_re[QW-1];
      neg_im_q <= q_im[QW-1];
    end

    if ((state_q == S_DECIDE) && (err_q != ST_OK)) begin
      status_q <= err_q;
      tidx_q   <= '0;
      res_re_q <= '0;
      res_im_q <= '0;
      last_q   <= 1'b1;
    end else if ((state_q == S_DIV) && div_done) begin
      status_q <= ST_OK;
      tidx_q   <= TIDX_W'(m_q);
      res_re_q <= sat_re;
      res_im_q <= sat_im;
      last_q   <= (m_q == LAST_IDX);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign time_index_o = tidx_q;
  assign resp_re_o    = res_re_q;
  assign resp_im_o    = res_im_q;
  assign last_o       = last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while a result is pending.");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("Input not reopened after the final transfer of a sweep.");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (time_index_o == '0))
    else $error("Error result is not a single final transfer.");

  a_dividers_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done == div_done_im)
    else $error("Real and imaginary dividers out of step.");

endmodule

>>> tb/windowed_inverse_dft_checker.sv
// ----------------------------------------------------------------------------
// Windowed inverse DFT checker
// Watches the configuration port and both channels of the block. It keeps
// its own copy of the registers and the sweep store, predicts the check
// status or the windowed, scaled inverse DFT of every completed sweep, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module windowed_inverse_dft_checker
  import widft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [FREQ_W-1:0]     freq_hz_i,
  input  logic signed [15:0]    sample_re_i,
  input  logic signed [15:0]    sample_im_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            status_i,
  input  logic [TIDX_W-1:0]     time_index_i,
  input  logic signed [15:0]    resp_re_i,
  input  logic signed [15:0]    resp_im_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int NPTS = 64;
  localparam longint unsigned SIN_C [6] = '{64'd1686629713, 64'd693598668,
    64'd85569306, 64'd5026995, 64'd172272, 64'd3864};

  typedef struct packed {
    logic [1:0]         status;
    logic [TIDX_W-1:0]  tidx;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } bin_t;

  bin_t            bin_queue [$];
  logic [FREQ_W-1:0] sweep_freq [NPTS];
  longint          sweep_re [NPTS];
  longint          sweep_im [NPTS];
  int              load_cnt;
  logic [1:0]      win_sel;
  logic [TOL_W-1:0] tol_reg;
  longint          twid_c [NPTS];
  longint          twid_s [NPTS];

  function automatic longint unsigned quarter_wave(longint unsigned u);
    longint unsigned u2;
    longint unsigned p;
    u2 = (u * u) >> 30;
    p  = SIN_C[5];
    for (int k = 4; k >= 0; k--) p = SIN_C[k] - ((u2 * p) >> 30);
    return (u * p) >> 30;
  endfunction

  function automatic longint turn_sine(logic [31:0] t);
    longint unsigned f;
    longint unsigned m;
    f = {34'd0, t[29:0]};
    m = quarter_wave(t[30] ? ((64'd1 << 30) - f) : f);
    return t[31] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint turn_cosine(logic [31:0] t);
    return turn_sine(t + 32'h4000_0000);
  endfunction

  function automatic logic [31:0] turn_frac(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (((num % den) << 32) + den / 2) / den;
    return q[31:0];
  endfunction

  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint taper(logic [1:0] kind, int i);
    longint a0;
    longint a1;
    longint a2;
    longint acc;
    a0 = 450971566;
    a1 = 536870912;
    a2 = 85899346;
    if (kind == WIN_RECT) return 65536;
    if (kind == WIN_HANN) begin
      a0 = 536870912; a1 = 536870912; a2 = 0;
    end else if (kind == WIN_HAMMING) begin
      a0 = 579820585; a1 = 493921239; a2 = 0;
    end
    acc = a0 * (64'sd1 <<< 30) - a1 * turn_cosine(turn_frac(i, NPTS - 1))
          + a2 * turn_cosine(turn_frac(2 * i, NPTS - 1));
    acc = rnd_shift(acc, 44);
    if (acc < 0) acc = 0;
    if (acc > 65536) acc = 65536;
    return acc;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic [1:0] sweep_status();
    logic [63:0] span;
    logic [63:0] step;
    logic [63:0] scaled;
    logic [63:0] diff;
    logic [63:0] lhs;
    logic [63:0] rhs;
    if (sweep_freq[NPTS-1] <= sweep_freq[0]) return ST_ORDER;
    span = sweep_freq[NPTS-1] - sweep_freq[0];
    for (int i = 1; i < NPTS; i++) begin
      if (sweep_freq[i] <= sweep_freq[i-1]) return ST_ORDER;
      step   = sweep_freq[i] - sweep_freq[i-1];
      scaled = step * 64'(NPTS - 1);
      diff   = (scaled > span) ? scaled - span : span - scaled;
      lhs    = diff << 16;
      rhs    = 64'(tol_reg) * span;
      if (lhs > rhs) return ST_UNIFORM;
    end
    return ST_OK;
  endfunction

  task automatic predict_sweep();
    longint wr [NPTS];
    longint wi [NPTS];
    longint w;
    longint sr;
    longint si;
    int     n;
    bin_t   b;
    b.status = sweep_status();
    if (b.status != ST_OK) begin
      b.tidx = '0; b.re = '0; b.im = '0; b.last = 1'b1;
      bin_queue.insert(bin_queue.size(), b);
      return;
    end
    for (int k = 0; k < NPTS; k++) begin
      w     = taper(win_sel, k);
      wr[k] = rnd_shift(sweep_re[k] * w, 14);
      wi[k] = rnd_shift(sweep_im[k] * w, 14);
    end
    for (int m = 0; m < NPTS; m++) begin
      sr = 0;
      si = 0;
      for (int k = 0; k < NPTS; k++) begin
        n  = (k * m) % NPTS;
        sr += wr[k] * twid_c[n] - wi[k] * twid_s[n];
        si += wr[k] * twid_s[n] + wi[k] * twid_c[n];
      end
      b.tidx = m[TIDX_W-1:0];
      b.re   = clip16((2 * sr + (64'sd1 <<< 28)) >>> 29);
      b.im   = clip16((2 * si + (64'sd1 <<< 28)) >>> 29);
      b.last = (m == NPTS - 1);
      bin_queue.insert(bin_queue.size(), b);
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pending_o    = 0;
    for (int n = 0; n < NPTS; n++) begin
      twid_c[n] = rnd_shift(turn_cosine(turn_frac(n, NPTS)), 10);
      twid_s[n] = rnd_shift(turn_sine(turn_frac(n, NPTS)), 10);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bin_t b;
    if (!rst_ni) begin
      load_cnt = 0;
      win_sel  = WIN_RECT;
      tol_reg  = TOL_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WINDOW_TYPE) win_sel = cfg_data_i[1:0];
        else if (cfg_index_i == CFG_UNIF_TOL) tol_reg = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        sweep_freq[load_cnt] = freq_hz_i;
        sweep_re[load_cnt]   = longint'(sample_re_i);
        sweep_im[load_cnt]   = longint'(sample_im_i);
        load_cnt++;
        if (load_cnt == NPTS) begin
          load_cnt = 0;
          predict_sweep();
        end
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (bin_queue.size() == 0) begin
          report("unexpected transfer, time_index", time_index_i, -1);
        end else begin
          b = bin_queue.pop_front();
          if (status_i != b.status) report("status", status_i, b.status);
          if (time_index_i != b.tidx) report("time_index", time_index_i, b.tidx);
          if (resp_re_i != b.re) report("resp_re", resp_re_i, b.re);
          if (resp_im_i != b.im) report("resp_im", resp_im_i, b.im);
          if (last_i != b.last) report("last", last_i, b.last);
        end
      end
      pending_o = bin_queue.size();
    end
  end

endmodule

>>> tb/windowed_inverse_dft_tb.sv
// ----------------------------------------------------------------------------
// Windowed inverse DFT testbench
// Drives whole sweeps into the block: a directed sweep at the field extremes,
// then random uniform, jittered, out-of-order and non-uniform sweeps under
// all four windows and several tolerances, with random sender gaps, receiver
// stalls and a long receiver hold-off. The checker does the comparison.
// ----------------------------------------------------------------------------
module windowed_inverse_dft_tb;
  import widft_pkg::*;

  localparam int NPTS        = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 1500;

  localparam int SW_EDGE    = 0;
  localparam int SW_EXACT   = 1;
  localparam int SW_JITTER  = 2;
  localparam int SW_ORDER   = 3;
  localparam int SW_UNEVEN  = 4;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [FREQ_W-1:0]     freq_hz     = '0;
  logic signed [15:0]    sample_re   = '0;
  logic signed [15:0]    sample_im   = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [1:0]            status;
  logic [TIDX_W-1:0]     time_index;
  logic signed [15:0]    resp_re;
  logic signed [15:0]    resp_im;
  logic                  last;

  int fail_count;
  int pending;
  int checked;
  int cycles     = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int sweeps     = 0;
  logic hold_arm = 1'b0;

  logic [FREQ_W-1:0]  freq_tab [NPTS];
  logic signed [15:0] re_tab [NPTS];
  logic signed [15:0] im_tab [NPTS];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  windowed_inverse_dft i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .freq_hz_i    (freq_hz),
    .sample_re_i  (sample_re),
    .sample_im_i  (sample_im),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .time_index_o (time_index),
    .resp_re_o    (resp_re),
    .resp_im_o    (resp_im),
    .last_o       (last)
  );

  windowed_inverse_dft_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .freq_hz_i    (freq_hz),
    .sample_re_i  (sample_re),
    .sample_im_i  (sample_im),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .time_index_i (time_index),
    .resp_re_i    (resp_re),
    .resp_im_i    (resp_im),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    if (hold_arm && out_valid) begin
      hold_arm  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("windowed_inverse_dft verification failed");
      $finish;
    end
  end

  task automatic set_config(window_e win, logic [TOL_W-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_TYPE;
    cfg_data  <= CFG_DATA_W'(win);
    @(posedge clk_i);
    cfg_index <= CFG_UNIF_TOL;
    cfg_data  <= tol;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic build_sweep(int kind);
    logic [FREQ_W-1:0] base;
    logic [FREQ_W-1:0] step;
    int                j;
    int                dev;
    base = {8'($urandom_range(0, 200)), 32'($urandom)};
    step = $urandom_range(1, 1 << 20);
    for (int i = 0; i < NPTS; i++) begin
      re_tab[i] = $urandom;
      im_tab[i] = $urandom;
    end
    case (kind)
      SW_EDGE: begin
        step = 40'hFF_FFFF_FFFF / (NPTS - 1);
        for (int i = 0; i < NPTS; i++) begin
          freq_tab[i] = i * step;
          re_tab[i]   = i[0] ? -16'sd32768 : 16'sd32767;
          im_tab[i]   = i[1] ? 16'sd32767 : -16'sd32768;
        end
        re_tab[2] = '0;
        im_tab[2] = '0;
        re_tab[3] = -16'sd1;
        im_tab[3] = 16'sd1;
      end
      SW_JITTER: begin
        step        = $urandom_range(1000, 100000);
        freq_tab[0] = base;
        for (int i = 1; i < NPTS; i++) begin
          dev         = $urandom_range(0, 2 * (step / 256)) - step / 256;
          freq_tab[i] = freq_tab[i-1] + step + FREQ_W'(signed'(dev));
        end
      end
      default: begin
        for (int i = 0; i < NPTS; i++) freq_tab[i] = base + i * step;
        if (kind == SW_ORDER) begin
          j           = $urandom_range(1, NPTS - 1);
          freq_tab[j] = freq_tab[j-1];
        end else if (kind == SW_UNEVEN) begin
          j = $urandom_range(1, NPTS - 1);
          for (int i = j; i < NPTS; i++) freq_tab[i] = freq_tab[i] + 2 * step;
        end
      end
    endcase
  endtask

  task automatic send_sweep(int kind);
    build_sweep(kind);
    for (int i = 0; i < NPTS; i++) begin
      if ($urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(99) < gap_pct) @(posedge clk_i);
      end
      in_valid  <= 1'b1;
      freq_hz   <= freq_tab[i];
      sample_re <= re_tab[i];
      sample_im <= im_tab[i];
      do @(posedge clk_i); while (!in_ready);
    end
    sweeps++;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sweep(SW_EDGE);
    drain();

    set_config(WIN_HANN, 16'd0);
    gap_pct = 46;
    send_sweep(SW_EXACT);
    drain();

    set_config(WIN_HAMMING, 16'hFFFF);
    gap_pct   = 0;
    stall_pct = 46;
    hold_arm <= 1'b1;
    send_sweep(SW_JITTER);
    gap_pct   = 28;
    stall_pct = 28;
    send_sweep(SW_ORDER);
    drain();

    set_config(WIN_BLACKMAN, TOL_RESET);
    gap_pct   = 0;
    stall_pct = 0;
    send_sweep(SW_EXACT);
    drain();

    set_config(WIN_BLACKMAN, 16'($urandom_range(1, 65534)));
    stall_pct = 46;
    send_sweep(SW_UNEVEN);
    drain();

    $display("Ran %0d sweeps through all four windows, both check failures and", sweeps);
    $display("tolerances from 0 to full scale; %0d result transfers compared.", checked);
    if (fail_count == 0) begin
      $display("windowed_inverse_dft verification clean");
    end else begin
      $display("windowed_inverse_dft verification failed");
    end
    $finish;
  end

endmodule
